>>> rtl/core/sdsh_pkg.sv
// Shared types, phase codes and command constants of the SD card SPI host engine.
// Depends on nothing; used by every module of the engine.
package sdsh_pkg;

    localparam int PHASE_W = 6;
    localparam int CMD_W = 6;
    localparam int COUNT_W = 10;
    localparam int TIMER_W = 16;
    localparam int STATUS_W = 4;
    localparam int BLOCK_SHIFT = 9;
    localparam logic [COUNT_W-1:0] BLOCK_BYTES = 10'd512;
    localparam int CSD_DEPTH = 16;

    localparam logic [PHASE_W-1:0] PH_IDLE      = 6'd0;
    localparam logic [PHASE_W-1:0] PH_DUMMY     = 6'd1;
    localparam logic [PHASE_W-1:0] PH_CMD_READY = 6'd2;
    localparam logic [PHASE_W-1:0] PH_CMD_FRAME = 6'd3;
    localparam logic [PHASE_W-1:0] PH_CMD_RESP  = 6'd4;
    localparam logic [PHASE_W-1:0] PH_R7        = 6'd5;
    localparam logic [PHASE_W-1:0] PH_OCR       = 6'd6;
    localparam logic [PHASE_W-1:0] PH_CSD_TOKEN = 6'd7;
    localparam logic [PHASE_W-1:0] PH_CSD_DATA  = 6'd8;
    localparam logic [PHASE_W-1:0] PH_CSD_CRC   = 6'd9;
    localparam logic [PHASE_W-1:0] PH_RD_TOKEN  = 6'd10;
    localparam logic [PHASE_W-1:0] PH_RD_DATA   = 6'd11;
    localparam logic [PHASE_W-1:0] PH_RD_CRC    = 6'd12;
    localparam logic [PHASE_W-1:0] PH_WR_GAP    = 6'd13;
    localparam logic [PHASE_W-1:0] PH_WR_TOKEN  = 6'd14;
    localparam logic [PHASE_W-1:0] PH_WR_REQ    = 6'd15;
    localparam logic [PHASE_W-1:0] PH_WR_DATA   = 6'd16;
    localparam logic [PHASE_W-1:0] PH_WR_CRC    = 6'd17;
    localparam logic [PHASE_W-1:0] PH_WR_RESP   = 6'd18;
    localparam logic [PHASE_W-1:0] PH_WR_BUSY   = 6'd19;
    localparam logic [PHASE_W-1:0] PH_RELEASE   = 6'd20;

    localparam logic [2:0] JOB_NONE  = 3'd0;
    localparam logic [2:0] JOB_INIT  = 3'd1;
    localparam logic [2:0] JOB_CSD   = 3'd2;
    localparam logic [2:0] JOB_READ  = 3'd3;
    localparam logic [2:0] JOB_WRITE = 3'd4;

    localparam logic [2:0] OP_INIT  = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_WRITE = 3'd2;
    localparam logic [2:0] OP_BYTE  = 3'd3;
    localparam logic [2:0] OP_WDATA = 3'd4;
    localparam logic [2:0] OP_TICK  = 3'd5;

    localparam logic [CMD_W-1:0] CMD0  = 6'd0;
    localparam logic [CMD_W-1:0] CMD8  = 6'd8;
    localparam logic [CMD_W-1:0] CMD9  = 6'd9;
    localparam logic [CMD_W-1:0] CMD16 = 6'd16;
    localparam logic [CMD_W-1:0] CMD17 = 6'd17;
    localparam logic [CMD_W-1:0] CMD24 = 6'd24;
    localparam logic [CMD_W-1:0] CMD41 = 6'd41;
    localparam logic [CMD_W-1:0] CMD55 = 6'd55;
    localparam logic [CMD_W-1:0] CMD58 = 6'd58;

    localparam logic [STATUS_W-1:0] ST_OK          = 4'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CARD     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_INIT    = 4'd2;
    localparam logic [STATUS_W-1:0] ST_NO_IDLE     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_OP_TIMEOUT  = 4'd4;
    localparam logic [STATUS_W-1:0] ST_CMD_REJECT  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_TOKEN_TMO   = 4'd6;
    localparam logic [STATUS_W-1:0] ST_BAD_TOKEN   = 4'd7;
    localparam logic [STATUS_W-1:0] ST_WR_REJECT   = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BUSY_TMO    = 4'd9;

    localparam logic [1:0] REG_READY_TMO = 2'd0;
    localparam logic [1:0] REG_TOKEN_TMO = 2'd1;
    localparam logic [1:0] REG_BUSY_TMO  = 2'd2;
    localparam logic [1:0] REG_OPC_TMO   = 2'd3;

    localparam logic [7:0] BYTE_IDLE    = 8'hFF;
    localparam logic [7:0] TOKEN_START  = 8'hFE;
    localparam logic [7:0] R1_IDLE      = 8'h01;
    localparam logic [7:0] DATA_ACCEPT  = 8'h05;
    localparam logic [7:0] RESP_MASK    = 8'h1F;
    localparam logic [7:0] CMD_PREFIX   = 8'h40;
    localparam logic [7:0] CRC_CMD0     = 8'h95;
    localparam logic [7:0] CRC_CMD8     = 8'h87;
    localparam logic [7:0] CRC_DEFAULT  = 8'h01;
    localparam logic [31:0] ARG_CMD8    = 32'h0000_01AA;
    localparam logic [31:0] ARG_HCS     = 32'h4000_0000;

    typedef struct packed {
        logic                mosi_valid;
        logic [7:0]          mosi_byte;
        logic                chip_select_n;
        logic                fast_clock;
        logic                read_valid;
        logic [7:0]          read_data;
        logic                write_request;
        logic                done_res;
        logic [STATUS_W-1:0] status;
        logic                high_capacity;
        logic                ready_flag;
        logic [31:0]         sector_total;
    } result_t;

    // Byte k of a command frame: start byte, argument MSB first, then CRC.
    function automatic logic [7:0] frame_byte(input logic [2:0] k,
                                              input logic [CMD_W-1:0] idx,
                                              input logic [31:0] arg);
        logic [7:0] b;
        case (k)
            3'd0: b = CMD_PREFIX | {2'b00, idx};
            3'd1: b = arg[31:24];
            3'd2: b = arg[23:16];
            3'd3: b = arg[15:8];
            3'd4: b = arg[7:0];
            default: b = (idx == CMD0) ? CRC_CMD0 : ((idx == CMD8) ? CRC_CMD8 : CRC_DEFAULT);
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/sd_card_spi_host_engine_unit.sv
// Top level of the SD card SPI host engine: input handshake and result register.
// Depends on sdsh_pkg and sdsh_core.
//
// Usage: every input item is one event for the engine: a request (init, read
// block, write block), a byte received from the card, a write data byte or a
// millisecond tick. Each accepted item yields exactly one result item that
// says whether to start an SPI exchange (mosi_valid, mosi_byte), the chip
// select and clock rate levels, a received block byte, a write data request,
// request completion with its status, and the card state.
// An item is accepted when in_valid is high and in_stall is low; the result
// appears in the following cycle with out_valid and is taken when out_stall is low.
// One item is taken every cycle while in_stall is low: the whole next-state
// step runs between the state registers and the result register.
// While the receiver stalls a held result, in_stall is raised and nothing
// new is accepted; once the result is taken a new item enters in that cycle.
// Configuration writes (cfg_write, cfg_index, cfg_data) load the four
// timeouts in milliseconds. Reset idles the engine with chip select high,
// the slow clock selected, the card marked uninitialized and the default
// timeouts loaded. No memory clearing is needed after reset.
module sd_card_spi_host_engine_unit #(
    parameter int RESPONSE_POLLS = 10,
    parameter int IDLE_RETRIES = 10,
    parameter int CSD_TOKEN_POLLS = 1000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  opcode,
    input  logic [31:0] block_address,
    input  logic [7:0]  miso_byte,
    input  logic [7:0]  write_byte,
    input  logic        card_detect_n,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        mosi_valid,
    output logic [7:0]  mosi_byte,
    output logic        chip_select_n,
    output logic        fast_clock,
    output logic        read_valid,
    output logic [7:0]  read_data,
    output logic        write_request,
    output logic        done_res,
    output logic [3:0]  status,
    output logic        high_capacity,
    output logic        ready_flag,
    output logic [31:0] sector_total,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic accept;
    logic out_valid_reg, out_valid_next;
    sdsh_pkg::result_t result;
    sdsh_pkg::result_t res_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign accept = in_valid & ~in_stall;

    sdsh_core #(
        .RESPONSE_POLLS  (RESPONSE_POLLS),
        .IDLE_RETRIES    (IDLE_RETRIES),
        .CSD_TOKEN_POLLS (CSD_TOKEN_POLLS)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .opcode        (opcode),
        .block_address (block_address),
        .miso_byte     (miso_byte),
        .write_byte    (write_byte),
        .card_detect_n (card_detect_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .result        (result)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg & out_stall;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mosi_valid    = res_reg.mosi_valid;
    assign mosi_byte     = res_reg.mosi_byte;
    assign chip_select_n = res_reg.chip_select_n;
    assign fast_clock    = res_reg.fast_clock;
    assign read_valid    = res_reg.read_valid;
    assign read_data     = res_reg.read_data;
    assign write_request = res_reg.write_request;
    assign done_res      = res_reg.done_res;
    assign status        = res_reg.status;
    assign high_capacity = res_reg.high_capacity;
    assign ready_flag    = res_reg.ready_flag;
    assign sector_total  = res_reg.sector_total;

    // A received block byte always triggers the next exchange.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && read_valid) |-> mosi_valid)
        else $error("read byte without a following exchange");

    // The card is only marked ready after the run clock was selected.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && ready_flag) |-> fast_clock)
        else $error("card ready while on the slow clock");

    // Status carries a code only on a finishing result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |-> (status == sdsh_pkg::ST_OK))
        else $error("status set without completion");

    // No exchange is started while the engine waits for write data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && write_request) |-> !mosi_valid)
        else $error("exchange started while waiting for write data");

endmodule

>>> rtl/core/sdsh_sector.sv
// Converts the stored CSD register bytes into a 512-byte sector count.
// Depends on sdsh_pkg; handles CSD version 1 and version 2 layouts.
module sdsh_sector (
    input  logic [7:0]  csd [sdsh_pkg::CSD_DEPTH],
    output logic [31:0] sectors
);

    logic [22:0] v2_n;
    logic [11:0] v1_size;
    logic [12:0] v1_n;
    logic [2:0]  v1_mult;
    logic [4:0]  v1_e;
    logic [31:0] v1_wide;

    always_comb
    begin
        v2_n    = {1'b0, csd[7][5:0], csd[8], csd[9]} + 23'd1;
        v1_size = {csd[6][1:0], csd[7], csd[8][7:6]};
        v1_n    = {1'b0, v1_size} + 13'd1;
        v1_mult = {csd[9][1:0], csd[10][7]};
        v1_e    = {2'b00, v1_mult} + 5'd2 + {1'b0, csd[5][3:0]};
        v1_wide = {19'd0, v1_n};
        if (csd[0][7:6] == 2'b01)
        begin
            // A count of 2^22 units times 1024 no longer fits; it saturates.
            sectors = v2_n[22] ? 32'hFFFF_FFFF : {v2_n[21:0], 10'd0};
        end
        else if (v1_e >= 5'd9)
        begin
            sectors = v1_wide << (v1_e - 5'd9);
        end
        else
        begin
            sectors = v1_wide >> (5'd9 - v1_e);
        end
    end

endmodule

>>> rtl/core/sdsh_core.sv
// Protocol state machine of the SD card SPI host: start-up, CSD, block read/write.
// Depends on sdsh_pkg and sdsh_sector; computes one result per accepted item.
module sdsh_core #(
    parameter int RESPONSE_POLLS = 10,
    parameter int IDLE_RETRIES = 10,
    parameter int CSD_TOKEN_POLLS = 1000
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [2:0]            opcode,
    input  logic [31:0]           block_address,
    input  logic [7:0]            miso_byte,
    input  logic [7:0]            write_byte,
    input  logic                  card_detect_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    output sdsh_pkg::result_t     result
);

    localparam int CW = sdsh_pkg::COUNT_W;
    localparam int TW = sdsh_pkg::TIMER_W;
    localparam logic [CW-1:0] RESP_LIMIT = CW'(RESPONSE_POLLS);
    localparam logic [CW-1:0] RETRY_LIMIT = CW'(IDLE_RETRIES);
    localparam logic [CW-1:0] TOKEN_LIMIT = CW'(CSD_TOKEN_POLLS);

    logic [TW-1:0] ready_tmo_reg, token_tmo_reg, busy_tmo_reg, opc_tmo_reg;
    logic [sdsh_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [CW-1:0] byte_count_reg, byte_count_next;
    logic [CW-1:0] retry_count_reg, retry_count_next;
    logic [TW-1:0] ms_timer_reg, ms_timer_next;
    logic [TW-1:0] op_timer_reg, op_timer_next;
    logic card_v2_reg, card_v2_next;
    logic card_hc_reg, card_hc_next;
    logic card_ready_reg, card_ready_next;
    logic [31:0] sector_reg, sector_next;
    logic [31:0] card_address_reg, card_address_next;
    logic [7:0] last_response_reg, last_response_next;
    logic [sdsh_pkg::CMD_W-1:0] cmd_index_reg, cmd_index_next;
    logic [31:0] cmd_arg_reg, cmd_arg_next;
    logic [2:0] job_reg, job_next;
    logic [sdsh_pkg::STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic cs_reg, cs_next;
    logic fast_reg, fast_next;
    logic [7:0] csd_reg [sdsh_pkg::CSD_DEPTH];
    logic csd_we;
    logic [31:0] csd_sectors;

    // Deferred actions, resolved in the order the protocol nests them.
    logic cd_go;
    logic [7:0] cd_r;
    logic acmd_go, ocr_go, sc_go, rel_go;
    logic [sdsh_pkg::CMD_W-1:0] sc_idx;
    logic [31:0] sc_arg;
    logic [sdsh_pkg::STATUS_W-1:0] rel_st;
    logic [CW-1:0] bc_inc;

    sdsh_sector u_sector (
        .csd     (csd_reg),
        .sectors (csd_sectors)
    );

    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        retry_count_next   = retry_count_reg;
        ms_timer_next      = ms_timer_reg;
        op_timer_next      = op_timer_reg;
        card_v2_next       = card_v2_reg;
        card_hc_next       = card_hc_reg;
        card_ready_next    = card_ready_reg;
        sector_next        = sector_reg;
        card_address_next  = card_address_reg;
        last_response_next = last_response_reg;
        cmd_index_next     = cmd_index_reg;
        cmd_arg_next       = cmd_arg_reg;
        job_next           = job_reg;
        pend_status_next   = pend_status_reg;
        cs_next            = cs_reg;
        fast_next          = fast_reg;
        csd_we             = 1'b0;
        cd_go   = 1'b0;
        cd_r    = sdsh_pkg::BYTE_IDLE;
        acmd_go = 1'b0;
        ocr_go  = 1'b0;
        sc_go   = 1'b0;
        sc_idx  = sdsh_pkg::CMD0;
        sc_arg  = 32'd0;
        rel_go  = 1'b0;
        rel_st  = sdsh_pkg::ST_OK;
        bc_inc  = byte_count_reg + CW'(1);
        result.mosi_valid = 1'b0;
        result.mosi_byte  = sdsh_pkg::BYTE_IDLE;
        result.read_valid = 1'b0;
        result.read_data  = 8'd0;
        result.done_res   = 1'b0;
        result.status     = sdsh_pkg::ST_OK;

        if (opcode == sdsh_pkg::OP_INIT && phase_reg == sdsh_pkg::PH_IDLE)
        begin
            card_ready_next = 1'b0;
            fast_next = 1'b0;
            cs_next = 1'b1;
            if (card_detect_n)
            begin
                job_next = sdsh_pkg::JOB_NONE;
                result.done_res = 1'b1;
                result.status = sdsh_pkg::ST_NO_CARD;
            end
            else
            begin
                job_next = sdsh_pkg::JOB_INIT;
                phase_next = sdsh_pkg::PH_DUMMY;
                byte_count_next = '0;
                result.mosi_valid = 1'b1;
            end
        end
        else if ((opcode == sdsh_pkg::OP_READ || opcode == sdsh_pkg::OP_WRITE)
                 && phase_reg == sdsh_pkg::PH_IDLE)
        begin
            if (!card_ready_reg)
            begin
                job_next = sdsh_pkg::JOB_NONE;
                result.done_res = 1'b1;
                result.status = sdsh_pkg::ST_NOT_INIT;
            end
            else
            begin
                job_next = (opcode == sdsh_pkg::OP_READ) ? sdsh_pkg::JOB_READ
                                                         : sdsh_pkg::JOB_WRITE;
                card_address_next = card_hc_reg ? block_address
                    : {block_address[31-sdsh_pkg::BLOCK_SHIFT:0],
                       {sdsh_pkg::BLOCK_SHIFT{1'b0}}};
                cs_next = 1'b0;
                sc_go = 1'b1;
                sc_idx = (opcode == sdsh_pkg::OP_READ) ? sdsh_pkg::CMD17 : sdsh_pkg::CMD24;
                sc_arg = card_address_next;
            end
        end
        else if (opcode == sdsh_pkg::OP_BYTE && phase_reg != sdsh_pkg::PH_IDLE
                 && phase_reg != sdsh_pkg::PH_WR_REQ)
        begin
            case (phase_reg)
                sdsh_pkg::PH_DUMMY:
                begin
                    byte_count_next = bc_inc;
                    if (bc_inc >= CW'(10))
                    begin
                        cs_next = 1'b0;
                        retry_count_next = '0;
                        sc_go = 1'b1;
                    end
                    else
                    begin
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_CMD_READY:
                begin
                    if (miso_byte == sdsh_pkg::BYTE_IDLE)
                    begin
                        phase_next = sdsh_pkg::PH_CMD_FRAME;
                        byte_count_next = '0;
                        result.mosi_valid = 1'b1;
                        result.mosi_byte = sdsh_pkg::frame_byte(3'd0, cmd_index_reg, cmd_arg_reg);
                    end
                    else if (ms_timer_reg >= ready_tmo_reg)
                    begin
                        cd_go = 1'b1;
                    end
                    else
                    begin
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_CMD_FRAME:
                begin
                    byte_count_next = bc_inc;
                    result.mosi_valid = 1'b1;
                    if (bc_inc < CW'(6))
                    begin
                        result.mosi_byte = sdsh_pkg::frame_byte(bc_inc[2:0], cmd_index_reg,
                                                                cmd_arg_reg);
                    end
                    else
                    begin
                        phase_next = sdsh_pkg::PH_CMD_RESP;
                        byte_count_next = '0;
                    end
                end
                sdsh_pkg::PH_CMD_RESP:
                begin
                    if (!miso_byte[7])
                    begin
                        cd_go = 1'b1;
                        cd_r = miso_byte;
                    end
                    else
                    begin
                        byte_count_next = bc_inc;
                        if (bc_inc >= RESP_LIMIT)
                        begin
                            cd_go = 1'b1;
                        end
                        else
                        begin
                            result.mosi_valid = 1'b1;
                        end
                    end
                end
                sdsh_pkg::PH_R7:
                begin
                    byte_count_next = bc_inc;
                    if (bc_inc >= CW'(4))
                    begin
                        acmd_go = 1'b1;
                    end
                    else
                    begin
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_OCR:
                begin
                    if (byte_count_reg == '0)
                    begin
                        card_hc_next = miso_byte[6];
                    end
                    byte_count_next = bc_inc;
                    if (bc_inc >= CW'(4))
                    begin
                        ocr_go = 1'b1;
                    end
                    else
                    begin
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_CSD_TOKEN:
                begin
                    if (miso_byte == sdsh_pkg::TOKEN_START)
                    begin
                        phase_next = sdsh_pkg::PH_CSD_DATA;
                        byte_count_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                    else
                    begin
                        byte_count_next = bc_inc;
                        if (bc_inc >= TOKEN_LIMIT)
                        begin
                            rel_go = 1'b1;
                        end
                        else
                        begin
                            result.mosi_valid = 1'b1;
                        end
                    end
                end
                sdsh_pkg::PH_CSD_DATA:
                begin
                    csd_we = 1'b1;
                    byte_count_next = bc_inc;
                    if (bc_inc >= CW'(sdsh_pkg::CSD_DEPTH))
                    begin
                        phase_next = sdsh_pkg::PH_CSD_CRC;
                        byte_count_next = '0;
                    end
                    result.mosi_valid = 1'b1;
                end
                sdsh_pkg::PH_CSD_CRC:
                begin
                    byte_count_next = bc_inc;
                    if (bc_inc >= CW'(2))
                    begin
                        sector_next = csd_sectors;
                        rel_go = 1'b1;
                    end
                    else
                    begin
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_RD_TOKEN:
                begin
                    if (miso_byte == sdsh_pkg::BYTE_IDLE)
                    begin
                        if (ms_timer_reg >= token_tmo_reg)
                        begin
                            rel_go = 1'b1;
                            rel_st = sdsh_pkg::ST_TOKEN_TMO;
                        end
                        else
                        begin
                            result.mosi_valid = 1'b1;
                        end
                    end
                    else if (miso_byte == sdsh_pkg::TOKEN_START)
                    begin
                        phase_next = sdsh_pkg::PH_RD_DATA;
                        byte_count_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                    else
                    begin
                        rel_go = 1'b1;
                        rel_st = sdsh_pkg::ST_BAD_TOKEN;
                    end
                end
                sdsh_pkg::PH_RD_DATA:
                begin
                    result.read_valid = 1'b1;
                    result.read_data = miso_byte;
                    byte_count_next = bc_inc;
                    if (bc_inc >= sdsh_pkg::BLOCK_BYTES)
                    begin
                        phase_next = sdsh_pkg::PH_RD_CRC;
                        byte_count_next = '0;
                    end
                    result.mosi_valid = 1'b1;
                end
                sdsh_pkg::PH_RD_CRC:
                begin
                    byte_count_next = bc_inc;
                    if (bc_inc >= CW'(2))
                    begin
                        rel_go = 1'b1;
                    end
                    else
                    begin
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_WR_GAP:
                begin
                    phase_next = sdsh_pkg::PH_WR_TOKEN;
                    result.mosi_valid = 1'b1;
                    result.mosi_byte = sdsh_pkg::TOKEN_START;
                end
                sdsh_pkg::PH_WR_TOKEN:
                begin
                    phase_next = sdsh_pkg::PH_WR_REQ;
                    byte_count_next = '0;
                end
                sdsh_pkg::PH_WR_DATA:
                begin
                    byte_count_next = bc_inc;
                    if (bc_inc >= sdsh_pkg::BLOCK_BYTES)
                    begin
                        phase_next = sdsh_pkg::PH_WR_CRC;
                        byte_count_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                    else
                    begin
                        phase_next = sdsh_pkg::PH_WR_REQ;
                    end
                end
                sdsh_pkg::PH_WR_CRC:
                begin
                    byte_count_next = bc_inc;
                    if (bc_inc >= CW'(2))
                    begin
                        phase_next = sdsh_pkg::PH_WR_RESP;
                    end
                    result.mosi_valid = 1'b1;
                end
                sdsh_pkg::PH_WR_RESP:
                begin
                    if ((miso_byte & sdsh_pkg::RESP_MASK) != sdsh_pkg::DATA_ACCEPT)
                    begin
                        rel_go = 1'b1;
                        rel_st = sdsh_pkg::ST_WR_REJECT;
                    end
                    else
                    begin
                        phase_next = sdsh_pkg::PH_WR_BUSY;
                        ms_timer_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_WR_BUSY:
                begin
                    if (miso_byte == sdsh_pkg::BYTE_IDLE)
                    begin
                        rel_go = 1'b1;
                    end
                    else if (ms_timer_reg >= busy_tmo_reg)
                    begin
                        rel_go = 1'b1;
                        rel_st = sdsh_pkg::ST_BUSY_TMO;
                    end
                    else
                    begin
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::PH_RELEASE:
                begin
                    if (job_reg == sdsh_pkg::JOB_INIT && pend_status_reg == sdsh_pkg::ST_OK)
                    begin
                        job_next = sdsh_pkg::JOB_CSD;
                        fast_next = 1'b1;
                        cs_next = 1'b0;
                        sc_go = 1'b1;
                        sc_idx = sdsh_pkg::CMD9;
                    end
                    else
                    begin
                        if (job_reg == sdsh_pkg::JOB_CSD)
                        begin
                            card_ready_next = 1'b1;
                            result.status = sdsh_pkg::ST_OK;
                        end
                        else
                        begin
                            result.status = pend_status_reg;
                        end
                        phase_next = sdsh_pkg::PH_IDLE;
                        job_next = sdsh_pkg::JOB_NONE;
                        result.done_res = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (opcode == sdsh_pkg::OP_WDATA && phase_reg == sdsh_pkg::PH_WR_REQ)
        begin
            phase_next = sdsh_pkg::PH_WR_DATA;
            result.mosi_valid = 1'b1;
            result.mosi_byte = write_byte;
        end
        else if (opcode == sdsh_pkg::OP_TICK)
        begin
            if (ms_timer_reg != {TW{1'b1}})
            begin
                ms_timer_next = ms_timer_reg + TW'(1);
            end
            if (op_timer_reg != {TW{1'b1}})
            begin
                op_timer_next = op_timer_reg + TW'(1);
            end
        end

        // Response handling of the command that just completed.
        if (cd_go)
        begin
            last_response_next = cd_r;
            case (cmd_index_reg)
                sdsh_pkg::CMD0:
                begin
                    if (cd_r == sdsh_pkg::R1_IDLE)
                    begin
                        sc_go = 1'b1;
                        sc_idx = sdsh_pkg::CMD8;
                        sc_arg = sdsh_pkg::ARG_CMD8;
                    end
                    else
                    begin
                        retry_count_next = retry_count_reg + CW'(1);
                        if (retry_count_next >= RETRY_LIMIT)
                        begin
                            rel_go = 1'b1;
                            rel_st = sdsh_pkg::ST_NO_IDLE;
                        end
                        else
                        begin
                            sc_go = 1'b1;
                        end
                    end
                end
                sdsh_pkg::CMD8:
                begin
                    card_v2_next = (cd_r == sdsh_pkg::R1_IDLE);
                    if (card_v2_next)
                    begin
                        phase_next = sdsh_pkg::PH_R7;
                        byte_count_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                    else
                    begin
                        acmd_go = 1'b1;
                    end
                end
                sdsh_pkg::CMD55:
                begin
                    sc_go = 1'b1;
                    sc_idx = sdsh_pkg::CMD41;
                    sc_arg = card_v2_reg ? sdsh_pkg::ARG_HCS : 32'd0;
                end
                sdsh_pkg::CMD41:
                begin
                    sc_go = 1'b1;
                    if (cd_r == 8'd0)
                    begin
                        sc_idx = sdsh_pkg::CMD58;
                    end
                    else if (op_timer_reg >= opc_tmo_reg)
                    begin
                        sc_go = 1'b0;
                        rel_go = 1'b1;
                        rel_st = sdsh_pkg::ST_OP_TIMEOUT;
                    end
                    else
                    begin
                        sc_idx = sdsh_pkg::CMD55;
                    end
                end
                sdsh_pkg::CMD58:
                begin
                    card_hc_next = 1'b0;
                    if (cd_r == 8'd0)
                    begin
                        phase_next = sdsh_pkg::PH_OCR;
                        byte_count_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                    else
                    begin
                        ocr_go = 1'b1;
                    end
                end
                sdsh_pkg::CMD16:
                begin
                    rel_go = 1'b1;
                end
                sdsh_pkg::CMD9:
                begin
                    if (cd_r != 8'd0)
                    begin
                        rel_go = 1'b1;
                    end
                    else
                    begin
                        phase_next = sdsh_pkg::PH_CSD_TOKEN;
                        byte_count_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::CMD17:
                begin
                    if (cd_r != 8'd0)
                    begin
                        rel_go = 1'b1;
                        rel_st = sdsh_pkg::ST_CMD_REJECT;
                    end
                    else
                    begin
                        phase_next = sdsh_pkg::PH_RD_TOKEN;
                        ms_timer_next = '0;
                        result.mosi_valid = 1'b1;
                    end
                end
                sdsh_pkg::CMD24:
                begin
                    if (cd_r != 8'd0)
                    begin
                        rel_go = 1'b1;
                        rel_st = sdsh_pkg::ST_CMD_REJECT;
                    end
                    else
                    begin
                        phase_next = sdsh_pkg::PH_WR_GAP;
                        result.mosi_valid = 1'b1;
                    end
                end
                default:
                begin
                    rel_go = 1'b1;
                    rel_st = sdsh_pkg::ST_CMD_REJECT;
                end
            endcase
        end

        if (acmd_go)
        begin
            op_timer_next = '0;
            sc_go = 1'b1;
            sc_idx = sdsh_pkg::CMD55;
            sc_arg = 32'd0;
        end

        // Byte-addressed cards get their block length set to one sector.
        if (ocr_go)
        begin
            if (!card_hc_next)
            begin
                sc_go = 1'b1;
                sc_idx = sdsh_pkg::CMD16;
                sc_arg = {22'd0, sdsh_pkg::BLOCK_BYTES};
            end
            else
            begin
                rel_go = 1'b1;
            end
        end

        if (sc_go)
        begin
            cmd_index_next = sc_idx;
            cmd_arg_next = sc_arg;
            ms_timer_next = '0;
            byte_count_next = '0;
            result.mosi_valid = 1'b1;
            if (sc_idx == sdsh_pkg::CMD0)
            begin
                phase_next = sdsh_pkg::PH_CMD_FRAME;
                result.mosi_byte = sdsh_pkg::frame_byte(3'd0, sc_idx, sc_arg);
            end
            else
            begin
                phase_next = sdsh_pkg::PH_CMD_READY;
            end
        end

        if (rel_go)
        begin
            pend_status_next = rel_st;
            cs_next = 1'b1;
            phase_next = sdsh_pkg::PH_RELEASE;
            result.mosi_valid = 1'b1;
            result.mosi_byte = sdsh_pkg::BYTE_IDLE;
        end

        result.chip_select_n = cs_next;
        result.fast_clock    = fast_next;
        result.write_request = (phase_next == sdsh_pkg::PH_WR_REQ);
        result.high_capacity = card_hc_next;
        result.ready_flag    = card_ready_next;
        result.sector_total  = sector_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_tmo_reg     <= 16'd300;
            token_tmo_reg     <= 16'd300;
            busy_tmo_reg      <= 16'd500;
            opc_tmo_reg       <= 16'd1000;
            phase_reg         <= sdsh_pkg::PH_IDLE;
            byte_count_reg    <= '0;
            retry_count_reg   <= '0;
            ms_timer_reg      <= '0;
            op_timer_reg      <= '0;
            card_v2_reg       <= 1'b0;
            card_hc_reg       <= 1'b0;
            card_ready_reg    <= 1'b0;
            sector_reg        <= '0;
            card_address_reg  <= '0;
            last_response_reg <= 8'hFF;
            cmd_index_reg     <= sdsh_pkg::CMD0;
            cmd_arg_reg       <= '0;
            job_reg           <= sdsh_pkg::JOB_NONE;
            pend_status_reg   <= sdsh_pkg::ST_OK;
            cs_reg            <= 1'b1;
            fast_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    sdsh_pkg::REG_READY_TMO: ready_tmo_reg <= cfg_data;
                    sdsh_pkg::REG_TOKEN_TMO: token_tmo_reg <= cfg_data;
                    sdsh_pkg::REG_BUSY_TMO:  busy_tmo_reg  <= cfg_data;
                    default:                 opc_tmo_reg   <= cfg_data;
                endcase
            end
            if (accept)
            begin
                phase_reg         <= phase_next;
                byte_count_reg    <= byte_count_next;
                retry_count_reg   <= retry_count_next;
                ms_timer_reg      <= ms_timer_next;
                op_timer_reg      <= op_timer_next;
                card_v2_reg       <= card_v2_next;
                card_hc_reg       <= card_hc_next;
                card_ready_reg    <= card_ready_next;
                sector_reg        <= sector_next;
                card_address_reg  <= card_address_next;
                last_response_reg <= last_response_next;
                cmd_index_reg     <= cmd_index_next;
                cmd_arg_reg       <= cmd_arg_next;
                job_reg           <= job_next;
                pend_status_reg   <= pend_status_next;
                cs_reg            <= cs_next;
                fast_reg          <= fast_next;
            end
        end
    end

    // CSD bytes are payload; all sixteen are written before the size is read.
    always_ff @(posedge clk)
    begin
        if (accept && csd_we)
        begin
            csd_reg[byte_count_reg[3:0]] <= miso_byte;
        end
    end

endmodule

>>> test/tb_sd_card_spi_host_engine_unit.sv
// Self-checking testbench of the SD card SPI host engine unit.
// Depends on sdsh_pkg and sd_card_spi_host_engine_unit; a behavioral card answers every exchange.
module tb_sd_card_spi_host_engine_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPI_RESP_POLLS = 10;
    localparam int SPI_IDLE_RETRIES = 10;
    localparam int SPI_TOKEN_POLLS = 1000;
    localparam int RANDOM_ITEMS = 1850;
    localparam int STALL_LIMIT = 4000;
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]  op;
        logic [31:0] lba;
        logic [7:0]  miso;
        logic [7:0]  wbyte;
        logic        det_n;
    } event_t;

    typedef struct {
        event_t            ev;
        bit                typed;
        sdsh_pkg::result_t res;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  opcode;
    logic [31:0] block_address;
    logic [7:0]  miso_byte;
    logic [7:0]  write_byte;
    logic        card_detect_n;
    logic        out_valid;
    logic        out_stall;
    logic        mosi_valid;
    logic [7:0]  mosi_byte;
    logic        chip_select_n;
    logic        fast_clock;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        write_request;
    logic        done_res;
    logic [3:0]  status;
    logic        high_capacity;
    logic        ready_flag;
    logic [31:0] sector_total;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    sd_card_spi_host_engine_unit dut (.*);

    // Shadow copy of the engine state.
    logic [5:0]  eng_phase;
    int unsigned eng_count, eng_retries, tmr_ms, tmr_opc;
    bit          is_v2, is_hc, card_up, cs_n, fast;
    logic [31:0] sectors, card_addr, cur_arg;
    logic [7:0]  last_resp;
    logic [7:0]  csd_img [16];
    logic [5:0]  cur_cmd;
    logic [2:0]  cur_job;
    logic [3:0]  pend_st;
    logic [15:0] tmo_ready, tmo_token, tmo_busy, tmo_opc;
    sdsh_pkg::result_t nxt;

    sdsh_pkg::result_t expected_results [$];
    int          mismatches;
    int          useful_items;
    int          quiet_cycles;
    stim_row_t   directed [25];

    function automatic void emit_byte(logic [7:0] b);
        nxt.mosi_valid = 1'b1;
        nxt.mosi_byte = b;
    endfunction

    function automatic void end_request(logic [3:0] st);
        eng_phase = sdsh_pkg::PH_IDLE;
        cur_job = sdsh_pkg::JOB_NONE;
        nxt.done_res = 1'b1;
        nxt.status = st;
    endfunction

    function automatic void drop_select(logic [3:0] st);
        pend_st = st;
        cs_n = 1'b1;
        eng_phase = sdsh_pkg::PH_RELEASE;
        emit_byte(sdsh_pkg::BYTE_IDLE);
    endfunction

    function automatic logic [7:0] cmd_frame_byte(int unsigned k);
        case (k)
            0: return sdsh_pkg::CMD_PREFIX | {2'b00, cur_cmd};
            1: return cur_arg[31:24];
            2: return cur_arg[23:16];
            3: return cur_arg[15:8];
            4: return cur_arg[7:0];
            default: return (cur_cmd == sdsh_pkg::CMD0) ? sdsh_pkg::CRC_CMD0 :
                            ((cur_cmd == sdsh_pkg::CMD8) ? sdsh_pkg::CRC_CMD8
                                                         : sdsh_pkg::CRC_DEFAULT);
        endcase
    endfunction

    function automatic void begin_cmd(logic [5:0] idx, logic [31:0] arg);
        cur_cmd = idx;
        cur_arg = arg;
        tmr_ms = 0;
        eng_count = 0;
        if (idx == sdsh_pkg::CMD0) begin
            eng_phase = sdsh_pkg::PH_CMD_FRAME;
            emit_byte(cmd_frame_byte(0));
        end else begin
            eng_phase = sdsh_pkg::PH_CMD_READY;
            emit_byte(sdsh_pkg::BYTE_IDLE);
        end
    endfunction

    function automatic void begin_acmd();
        tmr_opc = 0;
        begin_cmd(sdsh_pkg::CMD55, 32'd0);
    endfunction

    function automatic void after_ocr();
        if (!is_hc)
            begin_cmd(sdsh_pkg::CMD16, 32'd512);
        else
            drop_select(sdsh_pkg::ST_OK);
    endfunction

    function automatic void decode_capacity();
        logic [63:0] n64;
        logic [31:0] csize, mult, e, n;
        if (csd_img[0][7:6] == 2'b01) begin
            n64 = {42'd0, csd_img[7][5:0], csd_img[8], csd_img[9]} + 64'd1;
            n64 = n64 * 64'd1024;
            sectors = (n64 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : n64[31:0];
        end else begin
            csize = {20'd0, csd_img[6][1:0], csd_img[7], csd_img[8][7:6]};
            mult = {29'd0, csd_img[9][1:0], csd_img[10][7]};
            e = mult + 32'd2 + {28'd0, csd_img[5][3:0]};
            n = csize + 32'd1;
            sectors = (e >= 9) ? (n << (e - 9)) : (n >> (9 - e));
        end
    endfunction

    function automatic void response_arrived(logic [7:0] r);
        last_resp = r;
        case (cur_cmd)
            sdsh_pkg::CMD0: begin
                if (r == sdsh_pkg::R1_IDLE) begin_cmd(sdsh_pkg::CMD8, sdsh_pkg::ARG_CMD8);
                else begin
                    eng_retries++;
                    if (eng_retries >= SPI_IDLE_RETRIES) drop_select(sdsh_pkg::ST_NO_IDLE);
                    else begin_cmd(sdsh_pkg::CMD0, 32'd0);
                end
            end
            sdsh_pkg::CMD8: begin
                is_v2 = (r == sdsh_pkg::R1_IDLE);
                if (is_v2) begin
                    eng_phase = sdsh_pkg::PH_R7;
                    eng_count = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end else begin_acmd();
            end
            sdsh_pkg::CMD55: begin_cmd(sdsh_pkg::CMD41, is_v2 ? sdsh_pkg::ARG_HCS : 32'd0);
            sdsh_pkg::CMD41: begin
                if (r == 8'h00) begin_cmd(sdsh_pkg::CMD58, 32'd0);
                else if (tmr_opc >= tmo_opc) drop_select(sdsh_pkg::ST_OP_TIMEOUT);
                else begin_cmd(sdsh_pkg::CMD55, 32'd0);
            end
            sdsh_pkg::CMD58: begin
                is_hc = 1'b0;
                if (r == 8'h00) begin
                    eng_phase = sdsh_pkg::PH_OCR;
                    eng_count = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end else after_ocr();
            end
            sdsh_pkg::CMD16: drop_select(sdsh_pkg::ST_OK);
            sdsh_pkg::CMD9: begin
                if (r != 8'h00) drop_select(sdsh_pkg::ST_OK);
                else begin
                    eng_phase = sdsh_pkg::PH_CSD_TOKEN;
                    eng_count = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end
            end
            sdsh_pkg::CMD17: begin
                if (r != 8'h00) drop_select(sdsh_pkg::ST_CMD_REJECT);
                else begin
                    eng_phase = sdsh_pkg::PH_RD_TOKEN;
                    tmr_ms = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end
            end
            sdsh_pkg::CMD24: begin
                if (r != 8'h00) drop_select(sdsh_pkg::ST_CMD_REJECT);
                else begin
                    eng_phase = sdsh_pkg::PH_WR_GAP;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end
            end
            default: drop_select(sdsh_pkg::ST_CMD_REJECT);
        endcase
    endfunction

    function automatic void card_byte(logic [7:0] r);
        case (eng_phase)
            sdsh_pkg::PH_DUMMY: begin
                eng_count++;
                if (eng_count >= 10) begin
                    cs_n = 1'b0;
                    eng_retries = 0;
                    begin_cmd(sdsh_pkg::CMD0, 32'd0);
                end else emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_CMD_READY: begin
                if (r == sdsh_pkg::BYTE_IDLE) begin
                    eng_phase = sdsh_pkg::PH_CMD_FRAME;
                    eng_count = 0;
                    emit_byte(cmd_frame_byte(0));
                end else if (tmr_ms >= tmo_ready) response_arrived(sdsh_pkg::BYTE_IDLE);
                else emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_CMD_FRAME: begin
                eng_count++;
                if (eng_count < 6) emit_byte(cmd_frame_byte(eng_count));
                else begin
                    eng_phase = sdsh_pkg::PH_CMD_RESP;
                    eng_count = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end
            end
            sdsh_pkg::PH_CMD_RESP: begin
                if (!r[7]) response_arrived(r);
                else begin
                    eng_count++;
                    if (eng_count >= SPI_RESP_POLLS) response_arrived(sdsh_pkg::BYTE_IDLE);
                    else emit_byte(sdsh_pkg::BYTE_IDLE);
                end
            end
            sdsh_pkg::PH_R7: begin
                eng_count++;
                if (eng_count >= 4) begin_acmd();
                else emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_OCR: begin
                if (eng_count == 0) is_hc = r[6];
                eng_count++;
                if (eng_count >= 4) after_ocr();
                else emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_CSD_TOKEN: begin
                if (r == sdsh_pkg::TOKEN_START) begin
                    eng_phase = sdsh_pkg::PH_CSD_DATA;
                    eng_count = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end else begin
                    eng_count++;
                    if (eng_count >= SPI_TOKEN_POLLS) drop_select(sdsh_pkg::ST_OK);
                    else emit_byte(sdsh_pkg::BYTE_IDLE);
                end
            end
            sdsh_pkg::PH_CSD_DATA: begin
                csd_img[eng_count & 15] = r;
                eng_count++;
                if (eng_count >= 16) begin
                    eng_phase = sdsh_pkg::PH_CSD_CRC;
                    eng_count = 0;
                end
                emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_CSD_CRC: begin
                eng_count++;
                if (eng_count >= 2) begin
                    decode_capacity();
                    drop_select(sdsh_pkg::ST_OK);
                end else emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_RD_TOKEN: begin
                if (r == sdsh_pkg::BYTE_IDLE) begin
                    if (tmr_ms >= tmo_token) drop_select(sdsh_pkg::ST_TOKEN_TMO);
                    else emit_byte(sdsh_pkg::BYTE_IDLE);
                end else if (r == sdsh_pkg::TOKEN_START) begin
                    eng_phase = sdsh_pkg::PH_RD_DATA;
                    eng_count = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end else drop_select(sdsh_pkg::ST_BAD_TOKEN);
            end
            sdsh_pkg::PH_RD_DATA: begin
                nxt.read_valid = 1'b1;
                nxt.read_data = r;
                eng_count++;
                if (eng_count >= 512) begin
                    eng_phase = sdsh_pkg::PH_RD_CRC;
                    eng_count = 0;
                end
                emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_RD_CRC: begin
                eng_count++;
                if (eng_count >= 2) drop_select(sdsh_pkg::ST_OK);
                else emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_WR_GAP: begin
                eng_phase = sdsh_pkg::PH_WR_TOKEN;
                emit_byte(sdsh_pkg::TOKEN_START);
            end
            sdsh_pkg::PH_WR_TOKEN: begin
                eng_phase = sdsh_pkg::PH_WR_REQ;
                eng_count = 0;
            end
            sdsh_pkg::PH_WR_DATA: begin
                eng_count++;
                if (eng_count >= 512) begin
                    eng_phase = sdsh_pkg::PH_WR_CRC;
                    eng_count = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end else eng_phase = sdsh_pkg::PH_WR_REQ;
            end
            sdsh_pkg::PH_WR_CRC: begin
                eng_count++;
                if (eng_count >= 2) eng_phase = sdsh_pkg::PH_WR_RESP;
                emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_WR_RESP: begin
                if ((r & sdsh_pkg::RESP_MASK) != sdsh_pkg::DATA_ACCEPT)
                    drop_select(sdsh_pkg::ST_WR_REJECT);
                else begin
                    eng_phase = sdsh_pkg::PH_WR_BUSY;
                    tmr_ms = 0;
                    emit_byte(sdsh_pkg::BYTE_IDLE);
                end
            end
            sdsh_pkg::PH_WR_BUSY: begin
                if (r == sdsh_pkg::BYTE_IDLE) drop_select(sdsh_pkg::ST_OK);
                else if (tmr_ms >= tmo_busy) drop_select(sdsh_pkg::ST_BUSY_TMO);
                else emit_byte(sdsh_pkg::BYTE_IDLE);
            end
            sdsh_pkg::PH_RELEASE: begin
                if (cur_job == sdsh_pkg::JOB_INIT && pend_st == sdsh_pkg::ST_OK) begin
                    cur_job = sdsh_pkg::JOB_CSD;
                    fast = 1'b1;
                    cs_n = 1'b0;
                    begin_cmd(sdsh_pkg::CMD9, 32'd0);
                end else if (cur_job == sdsh_pkg::JOB_CSD) begin
                    card_up = 1'b1;
                    end_request(sdsh_pkg::ST_OK);
                end else end_request(pend_st);
            end
            default: ;
        endcase
    endfunction

    // Advances the shadow engine by one item; returns whether the item had any effect.
    function automatic bit engine_step(event_t ev, output sdsh_pkg::result_t res);
        bit acted;
        acted = 1'b1;
        nxt = '0;
        nxt.mosi_byte = sdsh_pkg::BYTE_IDLE;
        if (ev.op == sdsh_pkg::OP_INIT && eng_phase == sdsh_pkg::PH_IDLE) begin
            card_up = 1'b0;
            fast = 1'b0;
            cs_n = 1'b1;
            if (ev.det_n) end_request(sdsh_pkg::ST_NO_CARD);
            else begin
                cur_job = sdsh_pkg::JOB_INIT;
                eng_phase = sdsh_pkg::PH_DUMMY;
                eng_count = 0;
                emit_byte(sdsh_pkg::BYTE_IDLE);
            end
        end else if ((ev.op == sdsh_pkg::OP_READ || ev.op == sdsh_pkg::OP_WRITE)
                     && eng_phase == sdsh_pkg::PH_IDLE) begin
            if (!card_up) end_request(sdsh_pkg::ST_NOT_INIT);
            else begin
                cur_job = (ev.op == sdsh_pkg::OP_READ) ? sdsh_pkg::JOB_READ
                                                       : sdsh_pkg::JOB_WRITE;
                card_addr = is_hc ? ev.lba : (ev.lba << sdsh_pkg::BLOCK_SHIFT);
                cs_n = 1'b0;
                begin_cmd((ev.op == sdsh_pkg::OP_READ) ? sdsh_pkg::CMD17 : sdsh_pkg::CMD24,
                          card_addr);
            end
        end else if (ev.op == sdsh_pkg::OP_BYTE && eng_phase != sdsh_pkg::PH_IDLE
                     && eng_phase != sdsh_pkg::PH_WR_REQ) begin
            card_byte(ev.miso);
        end else if (ev.op == sdsh_pkg::OP_WDATA && eng_phase == sdsh_pkg::PH_WR_REQ) begin
            eng_phase = sdsh_pkg::PH_WR_DATA;
            emit_byte(ev.wbyte);
        end else if (ev.op == sdsh_pkg::OP_TICK) begin
            if (tmr_ms < 32'hFFFF) tmr_ms++;
            if (tmr_opc < 32'hFFFF) tmr_opc++;
        end else acted = 1'b0;
        nxt.chip_select_n = cs_n;
        nxt.fast_clock = fast;
        nxt.write_request = (eng_phase == sdsh_pkg::PH_WR_REQ);
        nxt.high_capacity = is_hc;
        nxt.ready_flag = card_up;
        nxt.sector_total = sectors;
        res = nxt;
        return acted;
    endfunction

    // What a well-behaved card (with the odd fault) answers in the current phase.
    function automatic logic [7:0] card_answer();
        int unsigned p;
        p = $urandom_range(0, 99);
        case (eng_phase)
            sdsh_pkg::PH_CMD_READY:
                return (p < 85) ? sdsh_pkg::BYTE_IDLE : 8'($urandom_range(0, 254));
            sdsh_pkg::PH_CMD_RESP: begin
                if (p < 15) return sdsh_pkg::BYTE_IDLE;
                p = $urandom_range(0, 99);
                case (cur_cmd)
                    sdsh_pkg::CMD0: return (p < 90) ? sdsh_pkg::R1_IDLE : 8'($urandom);
                    sdsh_pkg::CMD8: return (p < 50) ? sdsh_pkg::R1_IDLE : 8'h05;
                    sdsh_pkg::CMD55: return sdsh_pkg::R1_IDLE;
                    sdsh_pkg::CMD41: return (p < 35) ? 8'h00 : sdsh_pkg::R1_IDLE;
                    sdsh_pkg::CMD58: return (p < 90) ? 8'h00 : 8'h05;
                    default: return (p < 88) ? 8'h00 : 8'h04;
                endcase
            end
            sdsh_pkg::PH_CSD_TOKEN:
                return (p < 85) ? sdsh_pkg::TOKEN_START : sdsh_pkg::BYTE_IDLE;
            sdsh_pkg::PH_CSD_DATA: begin
                if (eng_count == 0)
                    return {1'b0, p[0], 6'($urandom)};
                if (eng_count >= 7 && eng_count <= 9 && p < 30)
                    return 8'hFF;
                return 8'($urandom);
            end
            sdsh_pkg::PH_RD_TOKEN: begin
                if (p < 85) return sdsh_pkg::TOKEN_START;
                if (p < 95) return sdsh_pkg::BYTE_IDLE;
                return 8'($urandom_range(0, 8'hFD));
            end
            sdsh_pkg::PH_WR_RESP: return (p < 85) ? {3'($urandom), 5'h05} : 8'($urandom);
            sdsh_pkg::PH_WR_BUSY: return (p < 40) ? sdsh_pkg::BYTE_IDLE : 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic event_t next_event(bit allow_noise);
        event_t ev;
        int unsigned p;
        ev.op = sdsh_pkg::OP_BYTE;
        ev.lba = $urandom;
        ev.miso = 8'($urandom);
        ev.wbyte = 8'($urandom);
        ev.det_n = 1'b0;
        p = $urandom_range(0, 99);
        if (allow_noise && p < 7) begin
            ev.op = 3'($urandom_range(0, 7));
            ev.det_n = 1'($urandom);
        end else if (allow_noise && p < 12) begin
            ev.op = sdsh_pkg::OP_TICK;
        end else if (eng_phase == sdsh_pkg::PH_IDLE) begin
            p = $urandom_range(0, 99);
            if (!card_up) begin
                ev.op = (p < 90) ? sdsh_pkg::OP_INIT
                                 : ((p < 95) ? sdsh_pkg::OP_READ : sdsh_pkg::OP_WRITE);
                ev.det_n = ($urandom_range(0, 9) == 0);
            end else
                ev.op = (p < 45) ? sdsh_pkg::OP_READ
                                 : ((p < 90) ? sdsh_pkg::OP_WRITE : sdsh_pkg::OP_INIT);
        end else if (eng_phase == sdsh_pkg::PH_WR_REQ) begin
            ev.op = sdsh_pkg::OP_WDATA;
        end else begin
            ev.miso = card_answer();
        end
        return ev;
    endfunction

    function automatic stim_row_t row(logic [2:0] op, logic [31:0] lba, logic [7:0] miso,
                                      logic [7:0] wb, logic det, bit typed,
                                      logic [3:0] st, bit done, bit mv);
        stim_row_t r;
        r.ev = '{op, lba, miso, wb, det};
        r.typed = typed;
        r.res = '0;
        r.res.mosi_valid = mv;
        r.res.mosi_byte = sdsh_pkg::BYTE_IDLE;
        r.res.chip_select_n = 1'b1;
        r.res.done_res = done;
        r.res.status = st;
        return r;
    endfunction

    task automatic offer(event_t ev, bit typed, sdsh_pkg::result_t typed_res);
        sdsh_pkg::result_t res;
        bit acted;
        @(negedge clk);
        while (!(useful_items >= 300 && useful_items < 700) && $urandom_range(0, 99) < 30) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        opcode <= ev.op;
        block_address <= ev.lba;
        miso_byte <= ev.miso;
        write_byte <= ev.wbyte;
        card_detect_n <= ev.det_n;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        acted = engine_step(ev, res);
        if (acted) useful_items++;
        expected_results.push_back(typed ? typed_res : res);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(negedge clk);
        in_valid <= 1'b0;
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            sdsh_pkg::REG_READY_TMO: tmo_ready = val;
            sdsh_pkg::REG_TOKEN_TMO: tmo_token = val;
            sdsh_pkg::REG_BUSY_TMO: tmo_busy = val;
            default: tmo_opc = val;
        endcase
    endtask

    task automatic drain();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stall with one long hold-off to back the engine up.
    initial
    begin
        bit held;
        held = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (!held && useful_items >= 900) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
            end
            if (useful_items >= 1000 && useful_items < 1300)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < 30);
        end
    end

    always @(posedge clk)
    begin
        sdsh_pkg::result_t exp_r;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result item");
                mismatches++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("mosi_valid", exp_r.mosi_valid, mosi_valid);
                check_field("mosi_byte", exp_r.mosi_byte, mosi_byte);
                check_field("chip_select_n", exp_r.chip_select_n, chip_select_n);
                check_field("fast_clock", exp_r.fast_clock, fast_clock);
                check_field("read_valid", exp_r.read_valid, read_valid);
                check_field("read_data", exp_r.read_data, read_data);
                check_field("write_request", exp_r.write_request, write_request);
                check_field("done_res", exp_r.done_res, done_res);
                check_field("status", exp_r.status, status);
                check_field("high_capacity", exp_r.high_capacity, high_capacity);
                check_field("ready_flag", exp_r.ready_flag, ready_flag);
                check_field("sector_total", exp_r.sector_total, sector_total);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] settings [4];
        int target;
        int base;
        mismatches = 0;
        useful_items = 0;
        quiet_cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = sdsh_pkg::OP_TICK;
        block_address = '0;
        miso_byte = '0;
        write_byte = '0;
        card_detect_n = 1'b1;
        cfg_write = 1'b0;
        cfg_index = sdsh_pkg::REG_READY_TMO;
        cfg_data = '0;

        eng_phase = sdsh_pkg::PH_IDLE;
        eng_count = 0;
        eng_retries = 0;
        tmr_ms = 0;
        tmr_opc = 0;
        is_v2 = 0;
        is_hc = 0;
        card_up = 0;
        cs_n = 1'b1;
        fast = 1'b0;
        sectors = '0;
        card_addr = '0;
        cur_arg = '0;
        cur_cmd = sdsh_pkg::CMD0;
        cur_job = sdsh_pkg::JOB_NONE;
        pend_st = sdsh_pkg::ST_OK;
        last_resp = sdsh_pkg::BYTE_IDLE;
        tmo_ready = 16'd300;
        tmo_token = 16'd300;
        tmo_busy = 16'd500;
        tmo_opc = 16'd1000;
        foreach (csd_img[i]) csd_img[i] = '0;

        // Requests before init, absent card, stray items, then the start of an init.
        directed[0] = row(sdsh_pkg::OP_READ, 32'd0, 8'h00, 8'h00, 1'b0, 1,
                          sdsh_pkg::ST_NOT_INIT, 1, 0);
        directed[1] = row(sdsh_pkg::OP_WRITE, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b0, 1,
                          sdsh_pkg::ST_NOT_INIT, 1, 0);
        directed[2] = row(sdsh_pkg::OP_INIT, 32'd0, 8'h00, 8'h00, 1'b1, 1,
                          sdsh_pkg::ST_NO_CARD, 1, 0);
        directed[3] = row(sdsh_pkg::OP_BYTE, 32'd0, 8'hFF, 8'h00, 1'b0, 1,
                          sdsh_pkg::ST_OK, 0, 0);
        directed[4] = row(sdsh_pkg::OP_WDATA, 32'd0, 8'h00, 8'hFF, 1'b0, 1,
                          sdsh_pkg::ST_OK, 0, 0);
        directed[5] = row(OP_SPARE6, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1, 1,
                          sdsh_pkg::ST_OK, 0, 0);
        directed[6] = row(OP_SPARE7, 32'd0, 8'h00, 8'h00, 1'b1, 1, sdsh_pkg::ST_OK, 0, 0);
        directed[7] = row(sdsh_pkg::OP_TICK, 32'd0, 8'h00, 8'h00, 1'b0, 1,
                          sdsh_pkg::ST_OK, 0, 0);
        directed[8] = row(sdsh_pkg::OP_INIT, 32'd0, 8'h00, 8'h00, 1'b0, 1,
                          sdsh_pkg::ST_OK, 0, 1);
        for (int i = 9; i < 19; i++)
            directed[i] = row(sdsh_pkg::OP_BYTE, 32'd0, (i % 2) ? 8'h00 : 8'hFF, 8'h00, 1'b0,
                              0, sdsh_pkg::ST_OK, 0, 0);
        for (int i = 19; i < 25; i++)
            directed[i] = row(sdsh_pkg::OP_BYTE, 32'd0, 8'hFF, 8'h00, 1'b0, 0,
                              sdsh_pkg::ST_OK, 0, 0);

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed[i])
            offer(directed[i].ev, directed[i].typed, directed[i].res);

        // Four settings of the timeouts: the reset defaults, then both extremes, then small values.
        base = useful_items;
        for (int ph = 0; ph < 4; ph++) begin
            target = base + ((ph + 1) * RANDOM_ITEMS) / 4;
            while (useful_items < target)
                offer(next_event(1'b1), 1'b0, '0);
            while (eng_phase != sdsh_pkg::PH_IDLE)
                offer(next_event(1'b0), 1'b0, '0);
            @(negedge clk);
            in_valid <= 1'b0;
            drain();
            case (ph)
                0: settings = '{16'd1, 16'd1, 16'd1, 16'd1};
                1: settings = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
                2: settings = '{16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
                                16'($urandom_range(1, 4)), 16'($urandom_range(1, 4))};
                default: settings = '{16'd300, 16'd300, 16'd500, 16'd1000};
            endcase
            if (ph < 3) begin
                write_reg(sdsh_pkg::REG_READY_TMO, settings[0]);
                write_reg(sdsh_pkg::REG_TOKEN_TMO, settings[1]);
                write_reg(sdsh_pkg::REG_BUSY_TMO, settings[2]);
                write_reg(sdsh_pkg::REG_OPC_TMO, settings[3]);
            end
        end

        drain();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
